[rtl/dcrd_pkg.sv]
// Shared constants for the direction-cosine to RA/Dec converter.
// Fixed-point formats, CORDIC arctangent table, register indexes.
// No dependencies.
`timescale 1ns / 1ps

package dcrd_pkg;

    // internal unit: Q30, internal angles: 2^32 per turn
    localparam int WF            = 30;
    localparam int CORDIC_STAGES = 30;
    localparam int CORDIC_W      = 40;   // CORDIC x/y datapath width
    localparam int ANG_ZW        = 34;   // CORDIC angle accumulator width
    localparam int RAD_W         = 2 * WF + 1;
    localparam int ROOT_W        = WF + 1;
    localparam int INV_GAIN_Q30  = 652032874;

    localparam logic [63:0] UNIT_SQ = 64'd1 << (2 * WF);

    localparam logic signed [ANG_ZW-1:0] QUARTER_TURN = ANG_ZW'(64'h4000_0000);
    localparam logic signed [ANG_ZW-1:0] HALF_TURN    = ANG_ZW'(64'h8000_0000);

    localparam logic [31:0] ATAN_TAB [CORDIC_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTRE_RA  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTRE_DEC = 1'd1;

endpackage

[rtl/dcrd_if.sv]
// Channel interfaces: direction-cosine requests, sky-position results,
// configuration writes. Depends on dcrd_pkg.
`timescale 1ns / 1ps

interface dcrd_dir_if #(parameter int COSINE_FRAC_BITS = 16);
    logic                              valid;
    logic                              ready;
    logic signed [COSINE_FRAC_BITS+1:0] dir_l;
    logic signed [COSINE_FRAC_BITS+1:0] dir_m;
    logic                              in_last;

    modport source (output valid, dir_l, dir_m, in_last, input ready);
    modport sink   (input valid, dir_l, dir_m, in_last, output ready);
endinterface

interface dcrd_sky_if #(parameter int ANGLE_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic        [ANGLE_BITS-1:0] right_ascension;
    logic signed [ANGLE_BITS-1:0] declination;
    logic                         off_sphere;
    logic                         out_last;

    modport source (output valid, right_ascension, declination, off_sphere, out_last,
                    input ready);
    modport sink   (input valid, right_ascension, declination, off_sphere, out_last,
                    output ready);
endinterface

interface dcrd_cfg_if
    import dcrd_pkg::*;
    #(parameter int ANGLE_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [ANGLE_BITS-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/dcrd_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage (floor).
// Stand-alone; sideband data travels with each request.
`timescale 1ns / 1ps

module dcrd_sqrt_pipe #(
    parameter int RAD_W  = 61,
    parameter int ROOT_W = 31,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int TW = RAD_W + 2;

    logic              valid_reg [0:ROOT_W];
    logic [RAD_W-1:0]  rem_reg   [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg  [0:ROOT_W];
    logic [SIDE_W-1:0] side_reg  [0:ROOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= in_rad;
            root_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - k;
        logic [TW-1:0] trial;
        logic          fits;

        // (r + 2^b)^2 - r^2
        assign trial = (TW'(root_reg[k]) << (B + 1)) + (TW'(1) << (2 * B));
        assign fits  = TW'(rem_reg[k]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (en)
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= fits ? RAD_W'(TW'(rem_reg[k]) - trial) : rem_reg[k];
                root_reg[k+1] <= fits ? (root_reg[k] | (ROOT_W'(1) << B)) : root_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule

[rtl/dcrd_cordic_pipe.sv]
// Pipelined CORDIC, one micro-rotation per stage; rotation or vectoring mode.
// Depends on dcrd_pkg (arctangent table, widths).
`timescale 1ns / 1ps

module dcrd_cordic_pipe
    import dcrd_pkg::*;
#(
    parameter bit VECTORING = 1'b0,
    parameter int DW        = 40,
    parameter int SIDE_W    = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] in_x,
    input  logic signed [DW-1:0] in_y,
    input  logic        [31:0]   in_z,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic signed [DW-1:0] out_x,
    output logic signed [DW-1:0] out_y,
    output logic        [31:0]   out_z,
    output logic                 out_flag,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int NS = CORDIC_STAGES;

    logic                     valid_reg [0:NS];
    logic signed [DW-1:0]     x_reg     [0:NS];
    logic signed [DW-1:0]     y_reg     [0:NS];
    logic signed [ANG_ZW-1:0] z_reg     [0:NS];
    logic                     flag_reg  [0:NS];
    logic [SIDE_W-1:0]        side_reg  [0:NS];

    logic signed [DW-1:0]     x0, y0;
    logic signed [ANG_ZW-1:0] z0;
    logic                     flag0;

    // rotation: fold angles beyond a quarter turn (flag = negate results)
    // vectoring: move to the right half plane (flag = zero vector)
    always_comb
    begin
        x0    = in_x;
        y0    = in_y;
        z0    = '0;
        flag0 = 1'b0;
        if (VECTORING)
        begin
            flag0 = (in_x == '0) && (in_y == '0);
            if (in_x < 0)
            begin
                x0 = -in_x;
                y0 = -in_y;
                z0 = HALF_TURN;
            end
        end
        else
        begin
            z0 = ANG_ZW'($signed(in_z));
            if (z0 > QUARTER_TURN || z0 < -QUARTER_TURN)
            begin
                z0    = ANG_ZW'($signed(in_z + 32'h8000_0000));
                flag0 = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0;
            y_reg[0]    <= y0;
            z_reg[0]    <= z0;
            flag_reg[0] <= flag0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic                     sub;
        logic signed [DW-1:0]     xs, ys;
        logic signed [ANG_ZW-1:0] step;

        assign sub  = VECTORING ? (y_reg[k] < 0) : (z_reg[k] >= 0);
        assign xs   = x_reg[k] >>> k;
        assign ys   = y_reg[k] >>> k;
        assign step = $signed(ANG_ZW'(ATAN_TAB[k]));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (en)
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1]    <= sub ? x_reg[k] - ys : x_reg[k] + ys;
                y_reg[k+1]    <= sub ? y_reg[k] + xs : y_reg[k] - xs;
                z_reg[k+1]    <= sub ? z_reg[k] - step : z_reg[k] + step;
                flag_reg[k+1] <= flag_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[NS];
    assign out_x     = x_reg[NS];
    assign out_y     = y_reg[NS];
    assign out_z     = z_reg[NS][31:0];
    assign out_flag  = flag_reg[NS];
    assign out_side  = side_reg[NS];

endmodule

[rtl/direction_cosines_to_ra_dec.sv]
// Direction cosines (l, m) to right ascension / declination, inverse SIN
// projection about a programmable field centre. Top level.
// Depends on dcrd_pkg, dcrd_if, dcrd_sqrt_pipe, dcrd_cordic_pipe.
//
// Usage:
//   dir_in  : one request per (l, m, in_last); accepted when valid && ready.
//   sky_out : one result per request, same order, held until ready.
//   cfg     : register writes (index 0 centre RA, 1 centre Dec), always
//             ready; write only while no request is in flight.
// Depth: 133 register stages from an accepted request to sky_out.
// Throughput: one request per cycle unless stalled; pipelined datapath:
//   squares and 1 - p^2 (2), sin/cos CORDIC (31), square root (32),
//   products (4), square root (32), two parallel arctangent CORDICs (31),
//   plus the output register.
// Stall: the whole pipeline halts only when its last stage holds a result
//   and the output register is still full and not taken; otherwise
//   bubbles drain and new requests are taken. Nothing is lost or repeated.
// Reset: all valid bits clear, centre RA = 0, centre Dec = quarter turn.
`timescale 1ns / 1ps

module direction_cosines_to_ra_dec
    import dcrd_pkg::*;
#(
    parameter int COSINE_FRAC_BITS = 16,
    parameter int ANGLE_BITS       = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    dcrd_cfg_if.sink      cfg,
    dcrd_dir_if.sink      dir_in,
    dcrd_sky_if.source    sky_out
);

    localparam int CW2  = COSINE_FRAC_BITS + 2;
    localparam int UP   = WF - COSINE_FRAC_BITS;   // input scale to Q30
    localparam int DOWN = 32 - ANGLE_BITS;         // internal to output angle
    localparam logic [31:0] HALF_LSB =
        (DOWN == 0) ? 32'd0 : (32'd1 << ((DOWN == 0) ? 0 : DOWN - 1));
    localparam logic signed [65:0] T_MAX = 66'sd1 <<< WF;

    // sideband bundles
    typedef struct packed {
        logic [RAD_W-1:0]     rad;
        logic                 off;
        logic signed [CW2-1:0] l;
        logic signed [CW2-1:0] m;
        logic                 last;
    } sc_side_t;

    typedef struct packed {
        logic signed [31:0]    sd;
        logic signed [31:0]    cd;
        logic                  off;
        logic signed [CW2-1:0] l;
        logic signed [CW2-1:0] m;
        logic                  last;
    } rt1_side_t;

    typedef struct packed {
        logic signed [31:0]          t;
        logic signed [CORDIC_W-1:0]  x;
        logic signed [CW2-1:0]       l;
        logic                        off;
        logic                        last;
    } rt2_side_t;

    // ---------------- configuration ----------------
    logic [ANGLE_BITS-1:0] centre_ra_reg;
    logic [ANGLE_BITS-1:0] centre_dec_reg;
    logic [31:0]           d0, r0;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_ra_reg  <= '0;
            centre_dec_reg <= ANGLE_BITS'(1) << (ANGLE_BITS - 2);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_CENTRE_RA:  centre_ra_reg  <= cfg.data;
                REG_CENTRE_DEC: centre_dec_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // to 32-bit binary angles
    assign d0 = 32'(centre_dec_reg) << DOWN;
    assign r0 = 32'(centre_ra_reg) << DOWN;

    // ---------------- flow control ----------------
    logic fin_valid;
    logic out_valid_reg;
    logic en;

    assign en           = !fin_valid || !out_valid_reg || sky_out.ready;
    assign dir_in.ready = en;

    // ---------------- stage 1: squares ----------------
    logic                  v1_reg;
    logic signed [CW2-1:0] l1_reg, m1_reg;
    logic                  last1_reg;
    logic [2*CW2-1:0]      sql1_reg, sqm1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= dir_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_reg    <= dir_in.dir_l;
            m1_reg    <= dir_in.dir_m;
            last1_reg <= dir_in.in_last;
            sql1_reg  <= dir_in.dir_l * dir_in.dir_l;
            sqm1_reg  <= dir_in.dir_m * dir_in.dir_m;
        end
    end

    // ---------------- stage 2: 1 - p^2, horizon test ----------------
    logic [63:0]           ss;
    logic                  off_w;
    logic                  v2_reg;
    logic [RAD_W-1:0]      rad2_reg;
    logic                  off2_reg, last2_reg;
    logic signed [CW2-1:0] l2_reg, m2_reg;

    assign ss    = (64'(sql1_reg) + 64'(sqm1_reg)) << (2 * UP);
    assign off_w = ss > UNIT_SQ;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad2_reg  <= off_w ? '0 : RAD_W'(UNIT_SQ - ss);
            off2_reg  <= off_w;
            l2_reg    <= l1_reg;
            m2_reg    <= m1_reg;
            last2_reg <= last1_reg;
        end
    end

    // ---------------- sin/cos of centre Dec ----------------
    sc_side_t                   sc_in, sc_out;
    logic                       sc_valid, sc_neg;
    logic signed [CORDIC_W-1:0] sc_x, sc_y;

    assign sc_in = '{rad: rad2_reg, off: off2_reg, l: l2_reg, m: m2_reg, last: last2_reg};

    dcrd_cordic_pipe #(
        .VECTORING (1'b0),
        .DW        (CORDIC_W),
        .SIDE_W    ($bits(sc_side_t))
    ) u_sincos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_x      (CORDIC_W'(INV_GAIN_Q30)),
        .in_y      ('0),
        .in_z      (d0),
        .in_side   (sc_in),
        .out_valid (sc_valid),
        .out_x     (sc_x),
        .out_y     (sc_y),
        .out_z     (),
        .out_flag  (sc_neg),
        .out_side  (sc_out)
    );

    // ---------------- n = sqrt(1 - p^2) ----------------
    rt1_side_t         rt1_in, rt1_out;
    logic              rt1_valid;
    logic [ROOT_W-1:0] n_root;

    assign rt1_in.sd   = 32'(sc_neg ? -sc_y : sc_y);
    assign rt1_in.cd   = 32'(sc_neg ? -sc_x : sc_x);
    assign rt1_in.off  = sc_out.off;
    assign rt1_in.l    = sc_out.l;
    assign rt1_in.m    = sc_out.m;
    assign rt1_in.last = sc_out.last;

    dcrd_sqrt_pipe #(
        .RAD_W  (RAD_W),
        .ROOT_W (ROOT_W),
        .SIDE_W ($bits(rt1_side_t))
    ) u_sqrt_n (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sc_valid),
        .in_rad    (sc_out.rad),
        .in_side   (rt1_in),
        .out_valid (rt1_valid),
        .out_root  (n_root),
        .out_side  (rt1_out)
    );

    // ---------------- stage 3: rotation products ----------------
    logic                     v3_reg;
    logic signed [63:0]       p_cn3_reg, p_ns3_reg;
    logic signed [CW2+31:0]   p_ms3_reg, p_mc3_reg;
    logic signed [CW2-1:0]    l3_reg;
    logic                     off3_reg, last3_reg;
    logic signed [31:0]       n_s;

    assign n_s = $signed({1'b0, n_root});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= rt1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_cn3_reg <= rt1_out.cd * n_s;
            p_ns3_reg <= rt1_out.sd * n_s;
            p_ms3_reg <= rt1_out.m * rt1_out.sd;
            p_mc3_reg <= rt1_out.m * rt1_out.cd;
            l3_reg    <= rt1_out.l;
            off3_reg  <= rt1_out.off;
            last3_reg <= rt1_out.last;
        end
    end

    // ---------------- stage 4: x and asin argument ----------------
    logic signed [65:0]         x_full, t_full, t_sh, t_cl;
    logic                       v4_reg;
    logic signed [CORDIC_W-1:0] x4_reg;
    logic signed [31:0]         t4_reg;
    logic signed [CW2-1:0]      l4_reg;
    logic                       off4_reg, last4_reg;

    assign x_full = 66'(p_cn3_reg) - (66'(p_ms3_reg) <<< UP);
    assign t_full = 66'(p_ns3_reg) + (66'(p_mc3_reg) <<< UP);
    assign t_sh   = t_full >>> WF;

    always_comb
    begin
        t_cl = t_sh;
        if (t_sh > T_MAX)
            t_cl = T_MAX;
        else if (t_sh < -T_MAX)
            t_cl = -T_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x4_reg    <= CORDIC_W'(x_full >>> WF);
            t4_reg    <= 32'(t_cl);
            l4_reg    <= l3_reg;
            off4_reg  <= off3_reg;
            last4_reg <= last3_reg;
        end
    end

    // ---------------- stage 5: t^2 ----------------
    logic                       v5_reg;
    logic [63:0]                tt5_reg;
    logic signed [31:0]         t5_reg;
    logic signed [CORDIC_W-1:0] x5_reg;
    logic signed [CW2-1:0]      l5_reg;
    logic                       off5_reg, last5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tt5_reg   <= t4_reg * t4_reg;
            t5_reg    <= t4_reg;
            x5_reg    <= x4_reg;
            l5_reg    <= l4_reg;
            off5_reg  <= off4_reg;
            last5_reg <= last4_reg;
        end
    end

    // ---------------- stage 6: 1 - t^2 ----------------
    logic             v6_reg;
    logic [RAD_W-1:0] rad6_reg;
    rt2_side_t        rt2_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad6_reg <= RAD_W'(UNIT_SQ - tt5_reg);
            rt2_in   <= '{t: t5_reg, x: x5_reg, l: l5_reg, off: off5_reg, last: last5_reg};
        end
    end

    // ---------------- sqrt(1 - t^2) for asin ----------------
    rt2_side_t         rt2_out;
    logic              rt2_valid;
    logic [ROOT_W-1:0] c2_root;

    dcrd_sqrt_pipe #(
        .RAD_W  (RAD_W),
        .ROOT_W (ROOT_W),
        .SIDE_W ($bits(rt2_side_t))
    ) u_sqrt_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .in_rad    (rad6_reg),
        .in_side   (rt2_in),
        .out_valid (rt2_valid),
        .out_root  (c2_root),
        .out_side  (rt2_out)
    );

    // ---------------- arctangents, in lockstep ----------------
    logic        ra_valid, dec_valid;
    logic [31:0] ra_z, dec_z;
    logic        ra_zero, dec_zero;
    logic        ra_last, dec_off;

    dcrd_cordic_pipe #(
        .VECTORING (1'b1),
        .DW        (CORDIC_W),
        .SIDE_W    (1)
    ) u_atan_ra (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rt2_valid),
        .in_x      (rt2_out.x),
        .in_y      (CORDIC_W'(rt2_out.l) <<< UP),
        .in_z      ('0),
        .in_side   (rt2_out.last),
        .out_valid (ra_valid),
        .out_x     (),
        .out_y     (),
        .out_z     (ra_z),
        .out_flag  (ra_zero),
        .out_side  (ra_last)
    );

    dcrd_cordic_pipe #(
        .VECTORING (1'b1),
        .DW        (CORDIC_W),
        .SIDE_W    (1)
    ) u_atan_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rt2_valid),
        .in_x      (CORDIC_W'(c2_root)),
        .in_y      (CORDIC_W'(rt2_out.t)),
        .in_z      ('0),
        .in_side   (rt2_out.off),
        .out_valid (dec_valid),
        .out_x     (),
        .out_y     (),
        .out_z     (dec_z),
        .out_flag  (dec_zero),
        .out_side  (dec_off)
    );

    assign fin_valid = ra_valid && dec_valid;

    // ---------------- output register: offset, round ----------------
    logic [31:0]                  ra_sum;
    logic [33:0]                  dec_sum;
    logic [ANGLE_BITS-1:0]        ra_out_reg;
    logic signed [ANGLE_BITS-1:0] dec_out_reg;
    logic                         off_out_reg, last_out_reg;

    assign ra_sum  = r0 + (ra_zero ? 32'd0 : ra_z) + HALF_LSB;
    assign dec_sum = 34'($signed(dec_zero ? 32'd0 : dec_z)) + 34'(HALF_LSB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_valid && en)
            out_valid_reg <= 1'b1;
        else if (sky_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_valid && en)
        begin
            ra_out_reg   <= ra_sum[DOWN +: ANGLE_BITS];
            dec_out_reg  <= dec_sum[DOWN +: ANGLE_BITS];
            off_out_reg  <= dec_off;
            last_out_reg <= ra_last;
        end
    end

    assign sky_out.valid           = out_valid_reg;
    assign sky_out.right_ascension = ra_out_reg;
    assign sky_out.declination     = dec_out_reg;
    assign sky_out.off_sphere      = off_out_reg;
    assign sky_out.out_last        = last_out_reg;

endmodule

[verif/tb.sv]
// Self-checking bench for direction_cosines_to_ra_dec: fixed-point sky-position
// predictor, scoreboard class, request/result drivers with random idling.
// Depends on dcrd_pkg, dcrd_if and the RTL top level.
`timescale 1ns / 1ps

module tb
    import dcrd_pkg::*;
();

    typedef struct packed {
        logic [15:0]        ra;
        logic signed [15:0] dec;
        logic               off;
        logic               last;
    } sky_pos_t;

    // Predicts sky positions for accepted requests and checks results in order.
    class sky_scoreboard;
        logic [15:0] centre_ra  = 16'd0;
        logic [15:0] centre_dec = 16'h4000;
        sky_pos_t    pending[$];
        int          errors = 0;

        // integer square root, floor
        function longint unsigned root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // rotation CORDIC, Q30 sin/cos of a 32-bit binary angle
        function void sin_cos(logic [31:0] a, output longint s, output longint c);
            longint z, x, y, t;
            logic   flip;
            z = longint'(int'(a));
            x = longint'(INV_GAIN_Q30);
            y = 0;
            flip = 0;
            if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30))
            begin
                z = longint'(int'(a + 32'h8000_0000));
                flip = 1;
            end
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                if (z >= 0)
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= longint'(ATAN_TAB[i]);
                end
                else
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z += longint'(ATAN_TAB[i]);
                end
                x = t;
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        // vectoring CORDIC, atan2 as a 32-bit binary angle
        function logic [31:0] arc_tan2(longint y, longint x);
            logic [31:0] z;
            longint      t;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                if (y >= 0)
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z += ATAN_TAB[i];
                end
                else
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= ATAN_TAB[i];
                end
                x = t;
            end
            return z;
        endfunction

        function void note_request(logic signed [17:0] l, logic signed [17:0] m,
                                   logic last);
            longint          lq, mq, n, sd, cd, x, t, c2, dec;
            longint unsigned ss;
            logic [31:0]     ra;
            sky_pos_t        p;
            lq = longint'(l) * 16384;
            mq = longint'(m) * 16384;
            ss = longint'(lq * lq) + longint'(mq * mq);
            p.off = ss > UNIT_SQ;
            n = p.off ? 0 : longint'(root(UNIT_SQ - ss));
            sin_cos({centre_dec, 16'h0}, sd, cd);
            x = (cd * n - mq * sd) >>> WF;
            ra = {centre_ra, 16'h0} + arc_tan2(lq, x);
            t = (n * sd + mq * cd) >>> WF;
            if (t > (64'sd1 <<< WF)) t = 64'sd1 <<< WF;
            if (t < -(64'sd1 <<< WF)) t = -(64'sd1 <<< WF);
            c2 = longint'(root(UNIT_SQ - longint'(t * t)));
            dec = longint'(int'(arc_tan2(t, c2)));
            ra = ra + 32'h8000;
            p.ra = ra[31:16];
            dec = (dec + 32768) >>> 16;
            p.dec = dec[15:0];
            p.last = last;
            pending.push_back(p);
        endfunction

        function void check_result(logic [15:0] ra, logic signed [15:0] dec,
                                   logic off, logic last);
            sky_pos_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result ra=%0d dec=%0d", ra, dec);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ra !== e.ra)
            begin
                $error("right_ascension: expected %0d, got %0d", e.ra, ra);
                errors++;
            end
            if (dec !== e.dec)
            begin
                $error("declination: expected %0d, got %0d", e.dec, dec);
                errors++;
            end
            if (off !== e.off)
            begin
                $error("off_sphere: expected %0d, got %0d", e.off, off);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("out_last: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int LIMIT = 400000;

    logic clk = 0;
    logic rst_n = 0;
    int   cycles = 0;
    bit   quiet = 0;      // no idling on either side
    bit   hold_req = 0;   // receiver to hold off for a long stretch

    sky_scoreboard sb = new();

    dcrd_cfg_if #(16) cfg ();
    dcrd_dir_if #(16) dir ();
    dcrd_sky_if #(16) sky ();

    direction_cosines_to_ra_dec dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .dir_in  (dir),
        .sky_out (sky)
    );

    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("direction_cosines_to_ra_dec regression: fail");
            $finish;
        end
    end

    // register write; lowers valid and returns after the next edge, so back-to-back
    // calls never lower and raise valid in the same step
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        if (idx == REG_CENTRE_RA) sb.centre_ra = val;
        else sb.centre_dec = val;
        cfg.valid <= 0;
        @(posedge clk);
    endtask

    // offer one request; valid stays high into the next request when no gap
    task automatic send_request(logic signed [17:0] l, logic signed [17:0] m, logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            dir.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        dir.valid   <= 1;
        dir.dir_l   <= l;
        dir.dir_m   <= m;
        dir.in_last <= last;
        @(posedge clk);
        while (!dir.ready) @(posedge clk);
        sb.note_request(l, m, last);
    endtask

    // random positions: mostly inside the unit disc, some anywhere in the field range
    task automatic send_random();
        int sel;
        logic signed [17:0] l, m;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            l = 18'(int'($urandom_range(0, 92680)) - 46340);
            m = 18'(int'($urandom_range(0, 92680)) - 46340);
        end
        else if (sel == 6)
        begin
            l = 18'(int'($urandom_range(0, 131072)) - 65536);
            m = 18'(int'($urandom_range(0, 131072)) - 65536);
        end
        else if (sel == 7)
        begin
            l = 18'($urandom);
            m = 18'($urandom);
        end
        else if (sel == 8)
        begin
            // near the horizon
            l = 18'($urandom_range(0, 65536));
            m = 18'(int'(sb.root(64'd4294967296 - longint'(l) * l))
                    + int'($urandom_range(0, 4)) - 2);
            if ($urandom_range(0, 1)) l = -l;
            if ($urandom_range(0, 1)) m = -m;
        end
        else
        begin
            l = 18'(int'($urandom_range(0, 64)) - 32);
            m = 18'(int'($urandom_range(0, 64)) - 32);
        end
        send_request(l, m, 1'($urandom_range(0, 1)));
    endtask

    // idle point: all results in, valid low
    task automatic drain();
        dir.valid <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // result side: random ready stalls, long hold-off on request
    initial
    begin
        int k;
        sky.ready <= 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                sky.ready <= 0;
                repeat (400) @(posedge clk);
            end
            k = quiet ? 0 : $urandom_range(0, 7);
            if (k > 0)
            begin
                sky.ready <= 0;
                repeat (k) @(posedge clk);
            end
            sky.ready <= 1;
            @(posedge clk);
            while (!sky.valid) @(posedge clk);
            sb.check_result(sky.right_ascension, sky.declination,
                            sky.off_sphere, sky.out_last);
        end
    end

    initial
    begin
        logic [15:0] ra_set [6];
        logic [15:0] dec_set [6];
        ra_set  = '{16'd0, 16'd65535, 16'd0, 16'd12345, 16'd40000, 16'd0};
        dec_set = '{16'h4000, 16'hC000, 16'd0, 16'd5000, 16'h8000, 16'h4000};

        cfg.valid   <= 0;
        cfg.index   <= REG_CENTRE_RA;
        cfg.data    <= '0;
        dir.valid   <= 0;
        dir.dir_l   <= '0;
        dir.dir_m   <= '0;
        dir.in_last <= 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        for (int ph = 0; ph < 6; ph++)
        begin
            // phase 0 runs on the reset centre
            if (ph > 0)
            begin
                write_reg(REG_CENTRE_RA, ra_set[ph]);
                write_reg(REG_CENTRE_DEC, dec_set[ph]);
            end
            if (ph == 2) quiet = 1;
            // directed: centre, axes, horizon, off the sphere, field extremes
            send_request(0, 0, 0);
            send_request(18'sd65536, 0, 1);
            send_request(-18'sd65536, 0, 0);
            send_request(0, 18'sd65536, 0);
            send_request(0, -18'sd65536, 1);
            send_request(18'sd46341, 18'sd46341, 0);
            send_request(18'sd65536, 18'sd65536, 0);
            send_request(-18'sd131072, -18'sd131072, 1);
            send_request(18'sd131071, 18'sd131071, 0);
            send_request(18'sd131071, -18'sd131072, 1);
            send_request(1, -1, 0);
            send_request(-18'sd30000, 18'sd20000, 1);
            if (ph == 3)
            begin
                // stop taking results while requests keep coming: pipeline fills
                quiet = 1;
                hold_req = 1;
                repeat (250) send_random();
                quiet = 0;
            end
            else
                repeat (170) send_random();
            quiet = 0;
            drain();
        end

        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("direction_cosines_to_ra_dec regression: pass");
        else
            $display("direction_cosines_to_ra_dec regression: fail");
        $finish;
    end
endmodule

[direction_cosines_to_ra_dec.f]
rtl/dcrd_pkg.sv
rtl/dcrd_if.sv
rtl/dcrd_sqrt_pipe.sv
rtl/dcrd_cordic_pipe.sv
rtl/direction_cosines_to_ra_dec.sv
verif/tb.sv
